// ===== hdl/stt_pkg.sv =====
// ---------------------------------------------------------------------------
// stt_pkg
// Types, token kinds, scanner modes and character classes for the tokenizer.
// ---------------------------------------------------------------------------
package stt_pkg;

  localparam int TOK_BITS = 32;
  localparam int VAL_BITS = 63;
  localparam int HEX_DIGITS = 6;
  localparam logic [7:0] CH_NL = 8'h0A;

  localparam logic [5:0] K_EOF    = 6'd0;
  localparam logic [5:0] K_IDENT  = 6'd1;
  localparam logic [5:0] K_INT    = 6'd2;
  localparam logic [5:0] K_FLOAT  = 6'd3;
  localparam logic [5:0] K_STRING = 6'd4;
  localparam logic [5:0] K_HEX    = 6'd5;
  localparam logic [5:0] K_SLASH  = 6'd17;
  localparam logic [5:0] K_DOT    = 6'd30;
  localparam logic [5:0] K_ERROR  = 6'd32;

  localparam logic [2:0] E_NONE  = 3'd0;
  localparam logic [2:0] E_CHAR  = 3'd1;
  localparam logic [2:0] E_OVFL  = 3'd2;
  localparam logic [2:0] E_UNTERM = 3'd3;
  localparam logic [2:0] E_HEX   = 3'd4;

  typedef enum logic [12:0] {
    M_IDLE       = 13'b0000000000001,
    M_SLASH      = 13'b0000000000010,
    M_LINE       = 13'b0000000000100,
    M_BLOCK      = 13'b0000000001000,
    M_BLOCK_STAR = 13'b0000000010000,
    M_OP1        = 13'b0000000100000,
    M_IDENT      = 13'b0000001000000,
    M_INT        = 13'b0000010000000,
    M_INT_DOT    = 13'b0000100000000,
    M_FLOAT      = 13'b0001000000000,
    M_STR        = 13'b0010000000000,
    M_STR_ESC    = 13'b0100000000000,
    M_HEX        = 13'b1000000000000
  } mode_t;

  // Token fields; positions carry the full output widths
  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] offset;
    logic [19:0] line;
    logic [15:0] column;
    logic [31:0] length;
    logic [62:0] value;
    logic [2:0]  err;
    logic        esc;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    case (c)
      "+": return 6'd14;  "-": return 6'd15;  "*": return 6'd16;
      "/": return 6'd17;  "%": return 6'd18;  "=": return 6'd19;
      ">": return 6'd20;  "<": return 6'd21;  "{": return 6'd22;
      "}": return 6'd23;  "[": return 6'd24;  "]": return 6'd25;
      "(": return 6'd26;  ")": return 6'd27;  ":": return 6'd28;
      ",": return 6'd29;  ".": return 6'd30;  ";": return 6'd31;
      default: return K_EOF;
    endcase
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
    if (b == "=") begin
      case (a)
        "=": return 6'd6;  "!": return 6'd7;  ">": return 6'd8;
        "<": return 6'd9;  "+": return 6'd10; "-": return 6'd11;
        default: return K_EOF;
      endcase
    end
    if (a == "-" && b == ">") return 6'd12;
    if (a == "." && b == ".") return 6'd13;
    return K_EOF;
  endfunction

  function automatic logic starts_pair(input logic [7:0] c);
    return c == "=" || c == "!" || c == ">" || c == "<" || c == "+" || c == "-" || c == ".";
  endfunction

endpackage

// ===== hdl/stt_if.sv =====
// ---------------------------------------------------------------------------
// stt_in_if / stt_out_if
// Valid/ready channels for source characters and tokens.
// ---------------------------------------------------------------------------
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_source;
  modport source (output valid, ch, end_of_source, input ready);
  modport sink (input valid, ch, end_of_source, output ready);
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [31:0] start_offset;
  logic [19:0] start_line;
  logic [15:0] start_column;
  logic [31:0] token_length;
  logic [62:0] int_value;
  logic [2:0]  error_code;
  logic        bad_escape;
  logic        last_of_run;
  modport source (output valid, token_kind, start_offset, start_line, start_column,
                  token_length, int_value, error_code, bad_escape, last_of_run,
                  input ready);
  modport sink (input valid, token_kind, start_offset, start_line, start_column,
                token_length, int_value, error_code, bad_escape, last_of_run,
                output ready);
endinterface

// ===== hdl/stt_scan.sv =====
// ---------------------------------------------------------------------------
// stt_scan
// Scanner state and per-character mode logic; up to three tokens per step.
// ---------------------------------------------------------------------------
module stt_scan #(
  parameter int OFFSET_BITS = 32,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          ch,
  input  logic                eos,
  output stt_pkg::tok_t [2:0] toks,
  output logic [1:0]          tok_cnt_m1,
  output logic                tok_any
);
  import stt_pkg::*;

  mode_t mode_r, mode_nxt;
  logic [7:0] held_r, held_nxt;
  logic [OFFSET_BITS-1:0] ts_off_r, ts_off_nxt, off_r, off_nxt, dot_off_r, dot_off_nxt;
  logic [LINE_BITS-1:0] ts_line_r, ts_line_nxt, line_r, line_nxt, dot_line_r, dot_line_nxt;
  logic [COLUMN_BITS-1:0] ts_col_r, ts_col_nxt, col_r, col_nxt, dot_col_r, dot_col_nxt;
  logic [VAL_BITS-1:0] acc_r, acc_nxt;
  logic ovf_r, ovf_nxt, esc_r, esc_nxt;
  logic [2:0] hexn_r, hexn_nxt;
  logic [TOK_BITS-1:0] len_r, len_nxt;

  tok_t t [3];
  logic [1:0] n;

  // Multiply-by-ten with overflow check on 63 bits
  logic [VAL_BITS+3:0] mul10;
  logic [3:0] dig;
  assign dig = ch[3:0];
  assign mul10 = {4'd0, acc_r} * 67'd10 + {63'd0, dig};

  function automatic logic [31:0] ext_off(input logic [OFFSET_BITS-1:0] v);
    logic [47:0] w;
    w = 48'(v);
    return w[31:0];
  endfunction
  function automatic logic [19:0] ext_line(input logic [LINE_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[19:0];
  endfunction
  function automatic logic [15:0] ext_col(input logic [COLUMN_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  always_comb begin
    logic [TOK_BITS-1:0] len;
    logic [OFFSET_BITS-1:0] so;
    logic [LINE_BITS-1:0] sl;
    logic [COLUMN_BITS-1:0] sc;
    logic again;
    logic [5:0] k;
    tok_t z;
    mode_nxt = mode_r; held_nxt = held_r;
    ts_off_nxt = ts_off_r; ts_line_nxt = ts_line_r; ts_col_nxt = ts_col_r;
    off_nxt = off_r; line_nxt = line_r; col_nxt = col_r;
    dot_off_nxt = dot_off_r; dot_line_nxt = dot_line_r; dot_col_nxt = dot_col_r;
    acc_nxt = acc_r; ovf_nxt = ovf_r; esc_nxt = esc_r; hexn_nxt = hexn_r;
    len_nxt = len_r;
    len = len_r; so = ts_off_r; sl = ts_line_r; sc = ts_col_r;
    z = '0;
    t[0] = z; t[1] = z; t[2] = z;
    n = 2'd0;
    again = 1'b0;
    k = K_EOF;

    if (eos) begin
      z.offset = ext_off(so); z.line = ext_line(sl); z.column = ext_col(sc);
      z.length = len;
      case (mode_r)
        M_SLASH: begin z.kind = K_SLASH; t[0] = z; n = 2'd1; end
        M_OP1: begin
          k = single_kind(held_r);
          z.kind = (k != K_EOF) ? k : K_ERROR;
          z.err = (k != K_EOF) ? E_NONE : E_CHAR;
          t[0] = z; n = 2'd1;
        end
        M_IDENT: begin z.kind = K_IDENT; t[0] = z; n = 2'd1; end
        M_INT, M_INT_DOT: begin
          z.kind = ovf_r ? K_ERROR : K_INT;
          z.err = ovf_r ? E_OVFL : E_NONE;
          z.value = ovf_r ? '0 : acc_r;
          t[0] = z; n = 2'd1;
          if (mode_r == M_INT_DOT) begin
            z = '0;
            z.kind = K_DOT; z.offset = ext_off(dot_off_r);
            z.line = ext_line(dot_line_r); z.column = ext_col(dot_col_r);
            z.length = 32'd1;
            t[1] = z; n = 2'd2;
          end
        end
        M_FLOAT: begin z.kind = K_FLOAT; t[0] = z; n = 2'd1; end
        M_STR, M_STR_ESC: begin
          z.kind = K_ERROR; z.err = E_UNTERM; t[0] = z; n = 2'd1;
        end
        M_HEX: begin z.kind = K_ERROR; z.err = E_HEX; t[0] = z; n = 2'd1; end
        default: ;
      endcase
      z = '0;
      z.kind = K_EOF; z.offset = ext_off(off_r); z.line = ext_line(line_r);
      z.column = ext_col(col_r);
      t[n] = z; n = n + 2'd1;
      mode_nxt = M_IDLE;
    end else begin
      // First pass: modes that may finish a token and fall back to idle/op
      z.offset = ext_off(so); z.line = ext_line(sl); z.column = ext_col(sc);
      case (mode_r)
        M_IDLE: again = 1'b1;
        M_SLASH: begin
          if (ch == "/") mode_nxt = M_LINE;
          else if (ch == "*") mode_nxt = M_BLOCK;
          else begin
            z.kind = K_SLASH; z.length = len; t[0] = z; n = 2'd1; again = 1'b1;
          end
        end
        M_LINE: if (ch == CH_NL) mode_nxt = M_IDLE;
        M_BLOCK: if (ch == "*") mode_nxt = M_BLOCK_STAR;
        M_BLOCK_STAR: begin
          if (ch == "/") mode_nxt = M_IDLE;
          else if (ch != "*") mode_nxt = M_BLOCK;
        end
        M_OP1: begin
          k = pair_kind(held_r, ch);
          if (k != K_EOF) begin
            z.kind = k; z.length = 32'd2; t[0] = z; n = 2'd1; mode_nxt = M_IDLE;
            len = TOK_BITS'(2);
          end else begin
            k = single_kind(held_r);
            z.kind = (k != K_EOF) ? k : K_ERROR;
            z.err = (k != K_EOF) ? E_NONE : E_CHAR;
            z.length = len; t[0] = z; n = 2'd1; again = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_word(ch)) begin
            if (len != '1) len = len + 1'b1;
          end else begin
            z.kind = K_IDENT; z.length = len; t[0] = z; n = 2'd1; again = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(ch)) begin
            if (!ovf_r) begin
              if (mul10[VAL_BITS+3:VAL_BITS] != 4'd0) ovf_nxt = 1'b1;
              else acc_nxt = mul10[VAL_BITS-1:0];
            end
            if (len != '1) len = len + 1'b1;
          end else if (ch == ".") begin
            dot_off_nxt = off_r; dot_line_nxt = line_r; dot_col_nxt = col_r;
            mode_nxt = M_INT_DOT;
          end else begin
            z.kind = ovf_r ? K_ERROR : K_INT; z.err = ovf_r ? E_OVFL : E_NONE;
            z.value = ovf_r ? '0 : acc_r; z.length = len;
            t[0] = z; n = 2'd1; again = 1'b1;
          end
        end
        M_INT_DOT: begin
          if (is_digit(ch)) begin
            mode_nxt = M_FLOAT;
            // Count the dot and this digit
            if (len != '1) len = len + 1'b1;
            if (len != '1) len = len + 1'b1;
          end else begin
            z.kind = ovf_r ? K_ERROR : K_INT; z.err = ovf_r ? E_OVFL : E_NONE;
            z.value = ovf_r ? '0 : acc_r; z.length = len;
            t[0] = z; n = 2'd1;
            // Held dot now acts as the pending operator
            so = dot_off_r; sl = dot_line_r; sc = dot_col_r; len = 32'd1;
            z = '0;
            z.offset = ext_off(so); z.line = ext_line(sl); z.column = ext_col(sc);
            k = pair_kind(".", ch);
            if (k != K_EOF) begin
              z.kind = k; z.length = 32'd2; t[1] = z; n = 2'd2; mode_nxt = M_IDLE;
              ts_off_nxt = so; ts_line_nxt = sl; ts_col_nxt = sc;
            end else begin
              z.kind = K_DOT; z.length = 32'd1; t[1] = z; n = 2'd2; again = 1'b1;
            end
          end
        end
        M_FLOAT: begin
          if (is_digit(ch)) begin
            if (len != '1) len = len + 1'b1;
          end else begin
            z.kind = K_FLOAT; z.length = len; t[0] = z; n = 2'd1; again = 1'b1;
          end
        end
        M_STR: begin
          if (len != '1) len = len + 1'b1;
          if (ch == "\\") mode_nxt = M_STR_ESC;
          else if (ch == "\"") begin
            z.kind = K_STRING; z.esc = esc_r;
            z.length = len;
            t[0] = z; n = 2'd1; mode_nxt = M_IDLE;
          end
        end
        M_STR_ESC: begin
          if (len != '1) len = len + 1'b1;
          if (ch != "n" && ch != "t" && ch != "\"" && ch != "\\") esc_nxt = 1'b1;
          mode_nxt = M_STR;
        end
        M_HEX: begin
          if (is_xdigit(ch)) begin
            hexn_nxt = hexn_r + 3'd1;
            if (len != '1) len = len + 1'b1;
            if (hexn_r + 3'd1 >= 3'(HEX_DIGITS)) begin
              z.kind = K_HEX; z.length = len;
              t[0] = z; n = 2'd1; mode_nxt = M_IDLE;
            end
          end else begin
            z.kind = K_ERROR; z.err = E_HEX; z.length = len;
            t[0] = z; n = 2'd1; again = 1'b1;
          end
        end
        default: again = 1'b1;
      endcase

      // Second pass: start a new token from idle
      if (again) begin
        mode_nxt = M_IDLE;
        if (!is_space(ch)) begin
          ts_off_nxt = off_r; ts_line_nxt = line_r; ts_col_nxt = col_r;
          len = TOK_BITS'(1);
          z = '0;
          z.offset = ext_off(off_r); z.line = ext_line(line_r);
          z.column = ext_col(col_r); z.length = 32'd1;
          if (ch == "/") mode_nxt = M_SLASH;
          else if (ch == "\"") begin mode_nxt = M_STR; esc_nxt = 1'b0; end
          else if (ch == "#") begin mode_nxt = M_HEX; hexn_nxt = 3'd0; end
          else if (is_digit(ch)) begin
            mode_nxt = M_INT; ovf_nxt = 1'b0; acc_nxt = VAL_BITS'(dig);
          end else if (is_alpha(ch) || ch == "_") mode_nxt = M_IDENT;
          else if (starts_pair(ch)) begin mode_nxt = M_OP1; held_nxt = ch; end
          else begin
            k = single_kind(ch);
            z.kind = (k != K_EOF) ? k : K_ERROR;
            z.err = (k != K_EOF) ? E_NONE : E_CHAR;
            t[n] = z; n = n + 2'd1;
          end
        end
      end
      len_nxt = len;

      // Position counters saturate
      if (off_r != '1) off_nxt = off_r + 1'b1;
      if (ch == CH_NL) begin
        if (line_r != '1) line_nxt = line_r + 1'b1;
        col_nxt = COLUMN_BITS'(1);
      end else if (col_r != '1) col_nxt = col_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; held_r <= '0;
      ts_off_r <= '0; ts_line_r <= LINE_BITS'(1); ts_col_r <= COLUMN_BITS'(1);
      off_r <= '0; line_r <= LINE_BITS'(1); col_r <= COLUMN_BITS'(1);
      dot_off_r <= '0; dot_line_r <= LINE_BITS'(1); dot_col_r <= COLUMN_BITS'(1);
      acc_r <= '0; ovf_r <= 1'b0; esc_r <= 1'b0; hexn_r <= '0; len_r <= '0;
    end else if (step) begin
      mode_r <= mode_nxt; held_r <= held_nxt;
      ts_off_r <= ts_off_nxt; ts_line_r <= ts_line_nxt; ts_col_r <= ts_col_nxt;
      off_r <= off_nxt; line_r <= line_nxt; col_r <= col_nxt;
      dot_off_r <= dot_off_nxt; dot_line_r <= dot_line_nxt; dot_col_r <= dot_col_nxt;
      acc_r <= acc_nxt; ovf_r <= ovf_nxt; esc_r <= esc_nxt; hexn_r <= hexn_nxt;
      len_r <= len_nxt;
    end
  end

  assign toks[0] = t[0];
  assign toks[1] = t[1];
  assign toks[2] = t[2];
  assign tok_any = (n != 2'd0);
  assign tok_cnt_m1 = n - 2'd1;
endmodule

// ===== hdl/stt_outq.sv =====
// ---------------------------------------------------------------------------
// stt_outq
// Token queue: takes up to three tokens a cycle, drains one per transfer.
// ---------------------------------------------------------------------------
module stt_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  stt_pkg::tok_t [2:0] toks,
  input  logic [1:0]          cnt_m1,
  output logic                room,
  stt_out_if.source           out
);
  import stt_pkg::*;

  localparam int DEPTH = 8;
  tok_t q_r [DEPTH];
  logic     last_r [DEPTH];
  logic [2:0] wp_r, rp_r;
  logic [3:0] cnt_r;
  logic pop;
  logic [1:0] n;

  assign n = cnt_m1 + 2'd1;
  assign pop = out.valid && out.ready;
  // Three free entries, not counting the drain of this cycle
  assign room = cnt_r <= 4'(DEPTH - 3);

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) <= cnt_m1) begin
          q_r[wp_r + 3'(i)] <= toks[i];
          last_r[wp_r + 3'(i)] <= (2'(i) == cnt_m1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 3'(n);
      if (pop) rp_r <= rp_r + 3'd1;
      cnt_r <= cnt_r + (push ? 4'(n) : 4'd0) - (pop ? 4'd1 : 4'd0);
    end
  end

  assign out.valid        = cnt_r != 4'd0;
  assign out.token_kind   = q_r[rp_r].kind;
  assign out.start_offset = q_r[rp_r].offset;
  assign out.start_line   = q_r[rp_r].line;
  assign out.start_column = q_r[rp_r].column;
  assign out.token_length = q_r[rp_r].length;
  assign out.int_value    = q_r[rp_r].value;
  assign out.error_code   = q_r[rp_r].err;
  assign out.bad_escape   = q_r[rp_r].esc;
  assign out.last_of_run  = last_r[rp_r];
endmodule

// ===== hdl/source_text_tokenizer.sv =====
// ---------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: one source byte per transfer in, tokens out.
// ---------------------------------------------------------------------------
// Input channel in: one character per transfer, or an end marker that
// flushes the pending token and emits the end-of-file token.
// Output channel out: tokens, up to three per input, the last of each input
// marked by last_of_run.
// Throughput: one input per cycle while the token queue has room for three
// more tokens; the scanner mode logic handles each character combinationally.
// Output: a token is written into the token queue on the transfer of the
// character that completes it, and out shows the head of the queue.
// Reset: scanner idle, positions at offset 0, line 1, column 1, queue empty.
// Stall: when out is held, tokens collect in the eight-entry queue and
// in.ready drops while six or more wait, until entries drain.
// ---------------------------------------------------------------------------
module source_text_tokenizer #(
  parameter int OFFSET_BITS = 32,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  stt_in_if.sink    in,
  stt_out_if.source out
);
  import stt_pkg::*;

  tok_t [2:0] toks;
  logic [1:0] cnt_m1;
  logic any, room, step;

  assign in.ready = room;
  assign step = in.valid && in.ready;

  stt_scan #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS),
             .COLUMN_BITS(COLUMN_BITS)) u_scan (
    .clk, .rst_n, .step, .ch(in.ch), .eos(in.end_of_source),
    .toks, .tok_cnt_m1(cnt_m1), .tok_any(any)
  );

  stt_outq u_q (
    .clk, .rst_n, .push(step && any), .toks, .cnt_m1, .room, .out
  );
endmodule

// ===== hdl/stt_check.sv =====
// ---------------------------------------------------------------------------
// stt_check
// Port-level checks for the tokenizer.
// ---------------------------------------------------------------------------
module stt_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  out_kind,
  input logic [2:0]  out_err,
  input logic [62:0] out_val
);
  import stt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("token dropped");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_ERROR |-> out_err == E_NONE) else $error("stray error code");
  a_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_INT |-> out_val == '0) else $error("stray value");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("valid after reset");
endmodule

bind source_text_tokenizer stt_check u_check (
  .clk(clk), .rst_n(rst_n), .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready), .out_kind(out.token_kind),
  .out_err(out.error_code), .out_val(out.int_value)
);
